// File: rtl/mbss_pkg.sv
// Shared types and constants of the masked byte signature scanner.
package mbss_pkg;

   localparam int MAX_PATTERN_BYTES = 16;
   localparam int OFFSET_BITS       = 32;
   localparam int PATTERN_BYTES     = 16;
   localparam int PAT_IDX_W         = 4;
   localparam int LEN_W             = 5;
   localparam int MATCH_OFFSET_W    = 32;
   localparam int CSR_DATA_W        = 64;
   localparam int CSR_INDEX_W       = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_CARE_MASK    = 2'd2,
      CSR_PATTERN_LEN  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       region_end;
   } req_type;

   typedef struct packed {
      logic                      match_found;
      logic [MATCH_OFFSET_W-1:0] match_offset;
   } rsp_type;

   typedef struct packed {
      logic [63:0]              pattern_low;
      logic [63:0]              pattern_high;
      logic [PATTERN_BYTES-1:0] care_mask;
      logic [LEN_W-1:0]         pattern_length;
   } cfg_type;

endpackage

// File: rtl/mbss_csr.sv
// Configuration registers of the scanner.
module mbss_csr
   import mbss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   logic [63:0]              pattern_low_ff,  pattern_low_in;
   logic [63:0]              pattern_high_ff, pattern_high_in;
   logic [PATTERN_BYTES-1:0] care_mask_ff,    care_mask_in;
   logic [LEN_W-1:0]         pattern_len_ff,  pattern_len_in;

   always_comb begin
      pattern_low_in  = pattern_low_ff;
      pattern_high_in = pattern_high_ff;
      care_mask_in    = care_mask_ff;
      pattern_len_in  = pattern_len_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:  pattern_low_in  = csr_wdata[63:0];
            CSR_PATTERN_HIGH: pattern_high_in = csr_wdata[63:0];
            CSR_CARE_MASK:    care_mask_in    = csr_wdata[PATTERN_BYTES-1:0];
            CSR_PATTERN_LEN:  pattern_len_in  = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         care_mask_ff    <= '0;
         pattern_len_ff  <= LEN_W'(1);
      end else begin
         pattern_low_ff  <= pattern_low_in;
         pattern_high_ff <= pattern_high_in;
         care_mask_ff    <= care_mask_in;
         pattern_len_ff  <= pattern_len_in;
      end
   end

   assign cfg.pattern_low    = pattern_low_ff;
   assign cfg.pattern_high   = pattern_high_ff;
   assign cfg.care_mask      = care_mask_ff;
   assign cfg.pattern_length = pattern_len_ff;

endmodule

// File: rtl/mbss_scan.sv
// Sliding byte window, byte counter and masked pattern compare.
module mbss_scan
   import mbss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    accept,
   input  req_type item,
   output logic    push,
   output rsp_type result
);

   localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

   logic [7:0]             window_ff [MAX_PATTERN_BYTES];
   logic [7:0]             window_in [MAX_PATTERN_BYTES];
   logic [7:0]             shift_win [MAX_PATTERN_BYTES];
   logic [OFFSET_BITS-1:0] count_ff, count_in, count_inc;
   logic                   reported_ff, reported_in;

   logic [7:0]               pat [PATTERN_BYTES];
   logic [LEN_W-1:0]         len;
   logic [LEN_W-1:0]         pos;
   logic [MAX_PATTERN_BYTES-1:0] pos_ok;
   logic                     hit;

   // Active length: zero acts as one, clamp at the window depth.
   always_comb begin
      if (cfg.pattern_length == '0)
         len = LEN_W'(1);
      else if (cfg.pattern_length > LEN_W'(MAX_PATTERN_BYTES))
         len = LEN_W'(MAX_PATTERN_BYTES);
      else
         len = cfg.pattern_length;
   end

   always_comb begin
      for (int i = 0; i < PATTERN_BYTES / 2; i++) begin
         pat[i]                   = cfg.pattern_low[8*i +: 8];
         pat[i + PATTERN_BYTES/2] = cfg.pattern_high[8*i +: 8];
      end
   end

   // Window slot j holds pattern byte len-1-j once the new byte is in.
   always_comb begin
      pos = '0;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         shift_win[j] = (j == 0) ? item.data_byte : window_ff[(j == 0) ? 0 : j - 1];
         pos          = LEN_W'(len - LEN_W'(j) - LEN_W'(1));
         if (LEN_W'(j) < len && cfg.care_mask[pos[PAT_IDX_W-1:0]])
            pos_ok[j] = (shift_win[j] == pat[pos[PAT_IDX_W-1:0]]);
         else
            pos_ok[j] = 1'b1;
      end
   end

   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + OFFSET_BITS'(1);
   assign hit       = (count_inc >= OFFSET_BITS'(len)) && (&pos_ok);

   always_comb begin
      window_in   = window_ff;
      count_in    = count_ff;
      reported_in = reported_ff;
      push        = 1'b0;
      result      = '0;
      if (accept) begin
         if (!reported_ff) begin
            window_in = shift_win;
            count_in  = count_inc;
            if (hit) begin
               push                = 1'b1;
               result.match_found  = 1'b1;
               result.match_offset = MATCH_OFFSET_W'(count_inc - OFFSET_BITS'(len));
               reported_in         = 1'b1;
            end else if (item.region_end) begin
               push = 1'b1;
            end
         end
         // End of region re-arms whatever happened before.
         if (item.region_end) begin
            for (int j = 0; j < MAX_PATTERN_BYTES; j++)
               window_in[j] = '0;
            count_in    = '0;
            reported_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_PATTERN_BYTES; j++)
            window_ff[j] <= '0;
         count_ff    <= '0;
         reported_ff <= 1'b0;
      end else begin
         window_ff   <= window_in;
         count_ff    <= count_in;
         reported_ff <= reported_in;
      end
   end

endmodule

// File: rtl/mbss_out_buf.sv
// Two-entry result buffer between the scanner and the result channel.
module mbss_out_buf
   import mbss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_item,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   rsp_type head_ff, head_in;
   rsp_type tail_ff, tail_in;
   logic    head_valid_ff, head_valid_in;
   logic    tail_valid_ff, tail_valid_in;
   logic    pop;

   assign pop = head_valid_ff && !rsp_stall;

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      if (pop) begin
         if (tail_valid_ff) begin
            head_in       = tail_ff;
            tail_in       = push_item;
            tail_valid_in = push;
         end else begin
            head_in       = push_item;
            head_valid_in = push;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            tail_in       = push_item;
            tail_valid_in = 1'b1;
         end else begin
            head_in       = push_item;
            head_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign full      = tail_valid_ff;
   assign rsp_valid = head_valid_ff;
   assign rsp_item  = head_ff;

endmodule

// File: rtl/masked_byte_signature_scan.sv
// Top level of the masked byte signature scanner.
//
//   port group | dir | handshake          | payload
//   req_*      | in  | req_valid/req_stall | req_type: data_byte, region_end
//   rsp_*      | out | rsp_valid/rsp_stall | rsp_type: match_found, match_offset
//   csr_*      | in  | csr_write           | csr_index, csr_wdata
//
// One byte per cycle while req_stall is low: the window compare and the count
// update run in the cycle the byte is taken, and a result sits in the output
// buffer the next cycle. A two-entry output buffer lets bytes keep flowing while
// one result waits; req_stall rises only when both entries are occupied.
// Synchronous reset clears the window, the counter and the buffer, and loads
// the pattern length with one; no pass over storage follows it.
module masked_byte_signature_scan
   import mbss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_item,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   logic    accept;
   logic    push;
   logic    full;
   rsp_type push_item;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   mbss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mbss_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .accept (accept),
      .item   (req_item),
      .push   (push),
      .result (push_item)
   );

   mbss_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

// File: rtl/mbss_checker.sv
// Port-level checks of the scanner, bound to the top level.
module mbss_checker
   import mbss_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_item
);

   // No result comes out right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A not-found result carries a zero offset.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.match_found |-> rsp_item.match_offset == '0)
      else $error("not-found result with nonzero offset");

   // Input backpressure only when a result is already waiting.
   a_stall_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_item))
      else $error("stalled result changed");

endmodule

bind masked_byte_signature_scan mbss_checker u_mbss_checker (.*);

// File: tb/masked_byte_signature_scan_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the masked byte signature scanner.
module masked_byte_signature_scan_tb;
   import mbss_pkg::*;

   localparam int ITEM_TARGET  = 950;
   localparam int DRAIN_CYCLES = 6;
   localparam int LONG_HOLD    = 64;
   localparam int TIMEOUT_NS   = 500_000;

   typedef enum {STEP_CSR, STEP_DATA} step_kind_type;
   typedef enum {CHECK_MODEL, CHECK_NONE, CHECK_RESULT} check_kind_type;

   typedef struct {
      step_kind_type  kind;
      csr_index_type  index;
      logic [63:0]    value;
      logic [7:0]     data;
      int             reps;
      bit             last;
      check_kind_type check;
      logic           found;
      logic [31:0]    offset;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_item = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_item;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PATTERN_LOW;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // scanner state as the testbench sees it
   cfg_type     scan_cfg;
   logic [7:0]  recent_bytes [16];
   logic [31:0] region_count;
   bit          match_reported;

   rsp_type          pending_results [$];
   directed_row_type directed_rows [$];
   int               items_sent = 0;
   bit               failed = 1'b0;
   bit               hold_request = 1'b0;
   bit               data_burst = 1'b0;
   bit               result_burst = 1'b0;

   masked_byte_signature_scan dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

   function automatic void restart_region();
      int i;
      for (i = 0; i < 16; i++) recent_bytes[i] = 8'h00;
      region_count   = '0;
      match_reported = 1'b0;
   endfunction

   function automatic int effective_length();
      int len;
      len = scan_cfg.pattern_length;
      if (len < 1) len = 1;
      if (len > MAX_PATTERN_BYTES) len = MAX_PATTERN_BYTES;
      return len;
   endfunction

   // Returns 1 when the byte produces a result.
   function automatic bit scan_byte(req_type item, output rsp_type result);
      int           i;
      int           len;
      bit           hit;
      logic [127:0] pat;
      result = '0;
      if (match_reported) begin
         if (item.region_end) restart_region();
         return 1'b0;
      end
      for (i = 15; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
      recent_bytes[0] = item.data_byte;
      if (region_count != '1) region_count = region_count + 1;
      len = effective_length();
      pat = {scan_cfg.pattern_high, scan_cfg.pattern_low};
      hit = (region_count >= len);
      for (i = 0; i < len; i++) begin
         if (scan_cfg.care_mask[i] && recent_bytes[len-1-i] != pat[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
         result.match_found  = 1'b1;
         result.match_offset = region_count - len;
         if (item.region_end) restart_region();
         else match_reported = 1'b1;
         return 1'b1;
      end
      if (item.region_end) begin
         restart_region();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void add_write(csr_index_type index, logic [63:0] value);
      directed_row_type row;
      row = '{STEP_CSR, index, value, 8'h00, 0, 1'b0, CHECK_MODEL, 1'b0, 32'd0};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_bytes(logic [7:0] data, int reps, bit last,
                                     check_kind_type check,
                                     logic found, logic [31:0] offset);
      directed_row_type row;
      row = '{STEP_DATA, CSR_PATTERN_LOW, 64'd0, data, reps, last, check, found, offset};
      directed_rows.push_back(row);
   endfunction

   task automatic write_reg(csr_index_type index, logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_PATTERN_LOW:  scan_cfg.pattern_low    = value;
         CSR_PATTERN_HIGH: scan_cfg.pattern_high   = value;
         CSR_CARE_MASK:    scan_cfg.care_mask      = value[PATTERN_BYTES-1:0];
         CSR_PATTERN_LEN:  scan_cfg.pattern_length = value[LEN_W-1:0];
         default: ;
      endcase
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Called in the step of the last accept, so valid drops before the next edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_byte(logic [7:0] data, bit last, check_kind_type check,
                            rsp_type typed);
      int      gap;
      req_type item;
      rsp_type predicted;
      gap = data_burst ? 0 : $urandom_range(0, 5);
      item.data_byte  = data;
      item.region_end = last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
      if (scan_byte(item, predicted) && check == CHECK_MODEL) pending_results.push_back(predicted);
      if (check == CHECK_RESULT) pending_results.push_back(typed);
   endtask

   initial begin : result_sink
      int      pause;
      rsp_type want;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            pause = LONG_HOLD;
         end else begin
            pause = result_burst ? 0 : $urandom_range(0, 5);
         end
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (pending_results.size() == 0) begin
            $error("unexpected result: match_found %0b, match_offset %0d",
                   rsp_item.match_found, rsp_item.match_offset);
            failed = 1'b1;
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.match_found !== want.match_found) begin
               $error("match_found: expected %0b, got %0b", want.match_found,
                      rsp_item.match_found);
               failed = 1'b1;
            end
            if (rsp_item.match_offset !== want.match_offset) begin
               $error("match_offset: expected %0d, got %0d", want.match_offset,
                      rsp_item.match_offset);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin : stimulus
      directed_row_type row;
      rsp_type          typed;
      logic [7:0]       region_bytes [$];
      logic [127:0]     pat;
      logic [63:0]      noise;
      int               idx, i, k, len, span, pos, pick, tries, phase;
      bit               close;

      scan_cfg = '0;
      scan_cfg.pattern_length = 1;
      restart_region();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // all care bits clear after reset: the first byte matches
      add_bytes(8'h00, 1, 1'b1, CHECK_RESULT, 1'b1, 32'd0);
      // DE AD ?? EF, the third byte a wildcard; care bits past the length set
      add_write(CSR_PATTERN_LOW, 64'h0000_0000_EFBE_ADDE);
      add_write(CSR_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      add_write(CSR_CARE_MASK, 64'h0000_0000_0000_FFFB);
      add_write(CSR_PATTERN_LEN, 64'd4);
      add_bytes(8'h00, 1, 1'b0, CHECK_NONE, 1'b0, 32'd0);
      add_bytes(8'hDE, 1, 1'b0, CHECK_NONE, 1'b0, 32'd0);
      add_bytes(8'hAD, 1, 1'b0, CHECK_NONE, 1'b0, 32'd0);
      add_bytes(8'h55, 1, 1'b0, CHECK_NONE, 1'b0, 32'd0);
      add_bytes(8'hEF, 1, 1'b0, CHECK_RESULT, 1'b1, 32'd1);
      add_bytes(8'h11, 1, 1'b1, CHECK_NONE, 1'b0, 32'd0);
      // region shorter than the pattern
      add_bytes(8'hDE, 1, 1'b0, CHECK_NONE, 1'b0, 32'd0);
      add_bytes(8'hAD, 1, 1'b1, CHECK_RESULT, 1'b0, 32'd0);
      // match completed by the final byte
      add_bytes(8'hDE, 1, 1'b0, CHECK_NONE, 1'b0, 32'd0);
      add_bytes(8'hAD, 1, 1'b0, CHECK_NONE, 1'b0, 32'd0);
      add_bytes(8'h00, 1, 1'b0, CHECK_NONE, 1'b0, 32'd0);
      add_bytes(8'hEF, 1, 1'b1, CHECK_RESULT, 1'b1, 32'd0);
      // zero length acts as one
      add_write(CSR_PATTERN_LEN, 64'd0);
      add_write(CSR_PATTERN_LOW, 64'h0000_0000_0000_00FF);
      add_bytes(8'hFF, 1, 1'b1, CHECK_RESULT, 1'b1, 32'd0);
      add_bytes(8'h7F, 1, 1'b1, CHECK_RESULT, 1'b0, 32'd0);
      // length 31 acts as 16, all wildcards
      add_write(CSR_PATTERN_LEN, 64'd31);
      add_write(CSR_CARE_MASK, 64'd0);
      add_bytes(8'h80, 16, 1'b1, CHECK_RESULT, 1'b1, 32'd0);
      // pattern changed mid-region: the byte already held is compared too
      add_bytes(8'h12, 1, 1'b0, CHECK_NONE, 1'b0, 32'd0);
      add_write(CSR_PATTERN_LOW, 64'h0000_0000_0000_3412);
      add_write(CSR_CARE_MASK, 64'h0000_0000_0000_0003);
      add_write(CSR_PATTERN_LEN, 64'd2);
      add_bytes(8'h34, 1, 1'b0, CHECK_RESULT, 1'b1, 32'd0);
      add_bytes(8'h56, 1, 1'b1, CHECK_NONE, 1'b0, 32'd0);

      for (idx = 0; idx < directed_rows.size(); idx++) begin
         row = directed_rows[idx];
         if (row.kind == STEP_CSR) begin
            wait_drained();
            write_reg(row.index, row.value);
         end else begin
            typed.match_found  = row.found;
            typed.match_offset = row.offset;
            for (k = 1; k <= row.reps; k++)
               send_byte(row.data, row.last && k == row.reps,
                         (k == row.reps) ? row.check : CHECK_MODEL, typed);
         end
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_drained();
         pat = {$urandom, $urandom, $urandom, $urandom};
         case ($urandom_range(0, 5))
            0: pat = '0;
            1: pat = '1;
            default: ;
         endcase
         if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(CSR_PATTERN_LOW, pat[63:0]);
         if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(CSR_PATTERN_HIGH, pat[127:64]);
         // upper write data bits are random and must be ignored
         noise = {$urandom, $urandom};
         case ($urandom_range(0, 4))
            0: noise[15:0] = '0;
            1: noise[15:0] = '1;
            default: ;
         endcase
         if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(CSR_CARE_MASK, noise);
         noise = {$urandom, $urandom};
         case ($urandom_range(0, 7))
            0: noise[4:0] = 5'd0;
            1: noise[4:0] = 5'd16;
            2: noise[4:0] = 5'($urandom_range(17, 31));
            3: noise[4:0] = 5'd1;
            default: noise[4:0] = 5'($urandom_range(2, 6));
         endcase
         if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(CSR_PATTERN_LEN, noise);

         data_burst   = ($urandom_range(0, 3) == 0);
         result_burst = ($urandom_range(0, 3) == 0);
         len = effective_length();
         pat = {scan_cfg.pattern_high, scan_cfg.pattern_low};

         if (phase == 2) begin
            // one-byte regions back to back against a long receiver hold
            hold_request = 1'b1;
            data_burst   = 1'b1;
            repeat (24) send_byte(8'($urandom), 1'b1, CHECK_MODEL, '0);
         end else begin
            for (k = $urandom_range(2, 5); k > 0; k--) begin
               span = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(1, 24);
               region_bytes.delete();
               for (i = 0; i < span; i++) begin
                  pos = $urandom_range(0, len - 1);
                  if ($urandom_range(0, 2) == 0) region_bytes.push_back(pat[8*pos +: 8]);
                  else region_bytes.push_back(8'($urandom));
               end
               // mostly a planted pattern, some with one care byte corrupted
               pick = $urandom_range(0, 9);
               if (pick < 8 && span >= len) begin
                  pos = $urandom_range(0, span - len);
                  for (i = 0; i < len; i++)
                     if (scan_cfg.care_mask[i]) region_bytes[pos+i] = pat[8*i +: 8];
                  if (pick >= 6) begin
                     for (tries = 0; tries < 16; tries++) begin
                        i = $urandom_range(0, len - 1);
                        if (scan_cfg.care_mask[i]) begin
                           region_bytes[pos+i] = region_bytes[pos+i] ^ 8'(1 << $urandom_range(0, 7));
                           tries = 16;
                        end
                     end
                  end
               end
               // now and then the last region stays open across the next writes
               close = !(k == 1 && $urandom_range(0, 5) == 0);
               for (i = 0; i < span; i++)
                  send_byte(region_bytes[i], close && i == span - 1, CHECK_MODEL, '0);
            end
         end
         phase++;
      end

      wait_drained();
      if (!failed)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
